@@ sv/lccl_pkg.sv @@
// Shared constants, codes and types of the charge loop.
package lccl_pkg;

	// duty register width
	localparam int DUTY_BITS = 8;

	// target current capacity*rate/1000 fits 21 bits
	localparam int TGT_W = 21;
	// working width of products and dividends
	localparam int ACC_W = (DUTY_BITS + 24 > 30) ? DUTY_BITS + 24 : 30;
	// multiplier operand width, one bit retired per cycle
	localparam int MUL_B_W = (DUTY_BITS > 14) ? DUTY_BITS : 14;
	localparam int CNT_W = $clog2(ACC_W + 1);

	localparam int DEAD_BAND_MA = 30;
	localparam int PERMILLE = 1000;
	localparam int TOP_LIMIT_MV = 4200;

	typedef logic [1:0] req_t;
	localparam req_t REQ_START = 2'd0;
	localparam req_t REQ_STOP = 2'd1;
	localparam req_t REQ_UPDATE = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_BUSY = 2'd1;
	localparam status_t ST_BAD_CFG = 2'd2;
	localparam status_t ST_IDLE_UPD = 2'd3;

	typedef logic [1:0] stage_t;
	localparam stage_t STG_IDLE = 2'd0;
	localparam stage_t STG_CC = 2'd1;
	localparam stage_t STG_CV = 2'd2;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_CAPACITY = 2'd0;
	localparam cfg_idx_t CFG_RATE = 2'd1;
	localparam cfg_idx_t CFG_TOP_V = 2'd2;
	localparam cfg_idx_t CFG_DUTY_MAX = 2'd3;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	// clamp the duty limit register to the duty range
	function automatic logic [DUTY_BITS-1:0] eff_max(input logic [7:0] dm);
		logic [DUTY_BITS+7:0] wide;
		logic [DUTY_BITS+7:0] mask;
		wide = (DUTY_BITS + 8)'(dm);
		mask = (DUTY_BITS + 8)'({DUTY_BITS{1'b1}});
		return (wide < mask) ? wide[DUTY_BITS-1:0] : mask[DUTY_BITS-1:0];
	endfunction

endpackage

@@ sv/lccl_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module lccl_mul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [lccl_pkg::ACC_W-1:0]      a,
	input  logic [lccl_pkg::MUL_B_W-1:0]    b,
	output lccl_pkg::unit_sts_t             sts,
	output logic [lccl_pkg::ACC_W-1:0]      prod
);

	logic [lccl_pkg::CNT_W-1:0]   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [lccl_pkg::ACC_W-1:0]   acc_q;
	logic [lccl_pkg::ACC_W-1:0]   mcand_q;
	logic [lccl_pkg::MUL_B_W-1:0] mplier_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= lccl_pkg::CNT_W'(lccl_pkg::MUL_B_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == lccl_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mcand_q <= a;
			mplier_q <= b;
		end else if (busy_q) begin
			// add the shifted multiplicand for each set bit
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q <= {mcand_q[lccl_pkg::ACC_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[lccl_pkg::MUL_B_W-1:1]};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign prod = acc_q;

endmodule

@@ sv/lccl_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module lccl_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lccl_pkg::ACC_W-1:0]    dividend,
	input  logic [lccl_pkg::TGT_W-1:0]    divisor,
	output lccl_pkg::unit_sts_t           sts,
	output logic [lccl_pkg::ACC_W-1:0]    quo
);

	logic [lccl_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [lccl_pkg::TGT_W-1:0] rem_q;
	logic [lccl_pkg::ACC_W-1:0] quo_q;
	logic [lccl_pkg::TGT_W-1:0] dvs_q;
	logic [lccl_pkg::TGT_W:0]   trial;
	logic [lccl_pkg::TGT_W:0]   diff;
	logic                       ge;

	always_comb begin
		trial = {rem_q, quo_q[lccl_pkg::ACC_W-1]};
		diff = trial - {1'b0, dvs_q};
		ge = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= lccl_pkg::CNT_W'(lccl_pkg::ACC_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == lccl_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits TGT_W bits
			rem_q <= ge ? diff[lccl_pkg::TGT_W-1:0] : trial[lccl_pkg::TGT_W-1:0];
			quo_q <= {quo_q[lccl_pkg::ACC_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo = quo_q;

endmodule

@@ sv/lipo_constant_current_charge_loop.sv @@
// Top level of the charge loop: registers, sequencer and result register.
//
// channel  dir   handshake            payload
// s_*      in    s_tvalid/s_tready    tdata: batt_mv, batt_ma; tuser: req_type
// m_*      out   m_tvalid/m_tready    tdata: duty_val, duty_write, charge_stage; tuser: status
// cfg_*    in    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item at a time. Stop, busy start, idle or CV updates go from idle straight to the finish
// state that loads the result register. Start: one serial multiply for the target check.
// CC update: at most three runs each of the shared one-bit-per-cycle multiplier and divider, for
// the target, the relative error and the step.
// A new item is taken while the previous result waits in the output register.
// Reset clears stage, duty, registers and all handshake state; cfg_ready is always high.
module lipo_constant_current_charge_loop (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] batt_mv, [31:16] batt_ma
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] duty_val, [8] duty_write, [10:9] charge_stage
	output logic [1:0]  m_tuser,   // [1:0] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int DB = lccl_pkg::DUTY_BITS;
	localparam int AW = lccl_pkg::ACC_W;
	localparam int TW = lccl_pkg::TGT_W;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_MUL_T = 10'b0000000010,
		S_DIV_T = 10'b0000000100,
		S_ERR   = 10'b0000001000,
		S_MUL_E = 10'b0000010000,
		S_DIV_E = 10'b0000100000,
		S_MUL_S = 10'b0001000000,
		S_DIV_S = 10'b0010000000,
		S_APPLY = 10'b0100000000,
		S_FIN   = 10'b1000000000
	} fsm_t;

	fsm_t state_q;

	logic [15:0] cap_q;
	logic [13:0] rate_q;
	logic [15:0] top_q;
	logic [7:0]  dmax_q;

	lccl_pkg::stage_t  stage_q;
	logic [DB-1:0]     duty_q;
	lccl_pkg::status_t res_status_q;
	logic              res_wr_q;
	lccl_pkg::req_t    req_q;
	logic [14:0]       cur_q;
	logic              inc_q;
	logic [TW-1:0]     tgt_q;
	logic [AW-1:0]     step_q;

	logic                        mul_start_q;
	logic [AW-1:0]               mul_a_q;
	logic [lccl_pkg::MUL_B_W-1:0] mul_b_q;
	lccl_pkg::unit_sts_t         mul_sts;
	logic [AW-1:0]               mul_prod;

	logic                        div_start_q;
	logic [AW-1:0]               div_n_q;
	logic [TW-1:0]               div_d_q;
	lccl_pkg::unit_sts_t         div_sts;
	logic [AW-1:0]               div_quo;

	logic [15:0]   m_tdata_q;
	logic [1:0]    m_tuser_q;
	logic          m_tvalid_q;

	logic          in_acc;
	logic          out_free;
	logic [DB-1:0] mx;
	logic [TW-1:0] cur_ext;
	logic [TW-1:0] diff_up;
	logic [TW-1:0] diff_dn;
	logic [AW-1:0] duty_ext;
	logic [AW-1:0] mx_ext;
	logic [AW-1:0] nd_inc;
	logic [AW-1:0] nd_dec;
	logic          cfg_bad;
	logic [DB+7:0] duty_wide;

	lccl_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.sts    (mul_sts),
		.prod   (mul_prod)
	);

	lccl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_n_q),
		.divisor  (div_d_q),
		.sts      (div_sts),
		.quo      (div_quo)
	);

	assign s_tready = (state_q == S_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		mx = lccl_pkg::eff_max(dmax_q);
		cur_ext = TW'(cur_q);
		diff_up = tgt_q - cur_ext;
		diff_dn = cur_ext - tgt_q;
		duty_ext = AW'(duty_q);
		mx_ext = AW'(mx);
		nd_inc = duty_ext + step_q;
		nd_dec = duty_ext - step_q;
		// zero target means product below one permille unit
		cfg_bad = (top_q == 16'd0) || (top_q > 16'(lccl_pkg::TOP_LIMIT_MV)) ||
			(mul_prod < AW'(lccl_pkg::PERMILLE));
		duty_wide = (DB + 8)'(duty_q);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
			rate_q <= '0;
			top_q <= '0;
			dmax_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lccl_pkg::CFG_CAPACITY: cap_q <= cfg_data;
				lccl_pkg::CFG_RATE:     rate_q <= cfg_data[13:0];
				lccl_pkg::CFG_TOP_V:    top_q <= cfg_data;
				lccl_pkg::CFG_DUTY_MAX: dmax_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stage_q <= lccl_pkg::STG_IDLE;
			duty_q <= '0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_FIN;
						unique case (s_tuser)
							lccl_pkg::REQ_START: begin
								if (stage_q == lccl_pkg::STG_IDLE) begin
									mul_start_q <= 1'b1;
									state_q <= S_MUL_T;
								end
							end
							lccl_pkg::REQ_STOP: stage_q <= lccl_pkg::STG_IDLE;
							lccl_pkg::REQ_UPDATE: begin
								if (stage_q == lccl_pkg::STG_CC) begin
									if (s_tdata[15:0] >= top_q) begin
										stage_q <= lccl_pkg::STG_CV;
									end else begin
										mul_start_q <= 1'b1;
										state_q <= S_MUL_T;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_MUL_T: begin
					if (mul_sts.done) begin
						if (req_q == lccl_pkg::REQ_START) begin
							if (!cfg_bad) begin
								duty_q <= '0;
								stage_q <= lccl_pkg::STG_CC;
							end
							state_q <= S_FIN;
						end else begin
							div_start_q <= 1'b1;
							state_q <= S_DIV_T;
						end
					end
				end
				S_DIV_T: begin
					if (div_sts.done)
						state_q <= S_ERR;
				end
				S_ERR: begin
					state_q <= S_FIN;
					if (tgt_q > cur_ext && diff_up > TW'(lccl_pkg::DEAD_BAND_MA)) begin
						if (duty_q < mx) begin
							mul_start_q <= 1'b1;
							state_q <= S_MUL_E;
						end
					end else if (cur_ext > tgt_q && diff_dn > TW'(lccl_pkg::DEAD_BAND_MA)) begin
						if (duty_q != '0) begin
							if (tgt_q == '0) begin
								state_q <= S_APPLY;
							end else begin
								mul_start_q <= 1'b1;
								state_q <= S_MUL_E;
							end
						end
					end
				end
				S_MUL_E: begin
					if (mul_sts.done) begin
						div_start_q <= 1'b1;
						state_q <= S_DIV_E;
					end
				end
				S_DIV_E: begin
					if (div_sts.done) begin
						mul_start_q <= 1'b1;
						state_q <= S_MUL_S;
					end
				end
				S_MUL_S: begin
					if (mul_sts.done) begin
						div_start_q <= 1'b1;
						state_q <= S_DIV_S;
					end
				end
				S_DIV_S: begin
					if (div_sts.done)
						state_q <= S_APPLY;
				end
				S_APPLY: begin
					// saturate at the limit going up and at zero going down
					if (inc_q)
						duty_q <= (nd_inc < mx_ext) ? nd_inc[DB-1:0] : mx;
					else
						duty_q <= (duty_ext > step_q) ? nd_dec[DB-1:0] : '0;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload, operands and result fields
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					req_q <= s_tuser;
					res_wr_q <= 1'b0;
					res_status_q <= lccl_pkg::ST_OK;
					// clamp drain readings to zero
					cur_q <= s_tdata[31] ? 15'd0 : s_tdata[30:16];
					mul_a_q <= AW'(cap_q);
					mul_b_q <= lccl_pkg::MUL_B_W'(rate_q);
					unique case (s_tuser)
						lccl_pkg::REQ_START: begin
							if (stage_q != lccl_pkg::STG_IDLE)
								res_status_q <= lccl_pkg::ST_BUSY;
						end
						lccl_pkg::REQ_UPDATE: begin
							if (stage_q == lccl_pkg::STG_IDLE)
								res_status_q <= lccl_pkg::ST_IDLE_UPD;
						end
						default: ;
					endcase
				end
			end
			S_MUL_T: begin
				if (mul_sts.done) begin
					if (req_q == lccl_pkg::REQ_START) begin
						if (cfg_bad)
							res_status_q <= lccl_pkg::ST_BAD_CFG;
						else
							res_wr_q <= 1'b1;
					end
					div_n_q <= mul_prod;
					div_d_q <= TW'(lccl_pkg::PERMILLE);
				end
			end
			S_DIV_T: begin
				if (div_sts.done)
					tgt_q <= div_quo[TW-1:0];
			end
			S_ERR: begin
				inc_q <= (tgt_q > cur_ext);
				mul_a_q <= (tgt_q > cur_ext) ? AW'(diff_up) : AW'(diff_dn);
				mul_b_q <= lccl_pkg::MUL_B_W'(lccl_pkg::PERMILLE);
				step_q <= mx_ext;
			end
			S_MUL_E: begin
				if (mul_sts.done) begin
					div_n_q <= mul_prod;
					div_d_q <= tgt_q;
				end
			end
			S_DIV_E: begin
				if (div_sts.done) begin
					// half the relative error in permille
					mul_a_q <= {1'b0, div_quo[AW-1:1]};
					mul_b_q <= lccl_pkg::MUL_B_W'(mx);
				end
			end
			S_MUL_S: begin
				if (mul_sts.done) begin
					div_n_q <= mul_prod;
					div_d_q <= TW'(lccl_pkg::PERMILLE);
				end
			end
			S_DIV_S: begin
				if (div_sts.done)
					step_q <= div_quo;
			end
			S_APPLY: res_wr_q <= 1'b1;
			S_FIN: begin
				if (out_free) begin
					m_tdata_q <= {5'd0, stage_q, res_wr_q, duty_wide[7:0]};
					m_tuser_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

`ifndef ASSERT_OFF
	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start_q |-> !mul_sts.busy)
		else $error("multiplier started while busy");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start_q |-> !div_sts.busy)
		else $error("divider started while busy");
	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_sts.busy && div_sts.busy))
		else $error("multiplier and divider busy together");
	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !mul_sts.busy && !div_sts.busy && !mul_start_q && !div_start_q)
		else $error("item accepted while arithmetic units active");
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> m_tuser == lccl_pkg::ST_OK)
		else $error("duty written with error status");
`endif

endmodule

@@ sim/tb_lipo_constant_current_charge_loop.sv @@
// Self-checking testbench for the constant-current charge loop: directed plan, then random phases.
module tb_lipo_constant_current_charge_loop;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_GOAL = 950;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 200;
	localparam int HOLD_CYCLES = 400;

	// request code with no meaning; the block answers it and changes nothing
	localparam lccl_pkg::req_t REQ_RSVD = 2'd3;

	typedef struct packed {
		lccl_pkg::status_t status;
		logic [7:0] duty;
		logic wr;
		lccl_pkg::stage_t stage;
	} charge_res_t;

	localparam charge_res_t NO_WANT = '0;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// item rows: code = request, arg0 = voltage, arg1 = current
	// register rows: code = register index, arg0 = value
	typedef struct {
		row_kind_t kind;
		logic [1:0] code;
		logic [15:0] arg0;
		logic [15:0] arg1;
		bit fixed;
		charge_res_t want;
	} plan_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;    // [15:0] batt_mv, [31:16] batt_ma
	logic [1:0] s_tuser = '0;     // [1:0] req_type
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;         // [7:0] duty_val, [8] duty_write, [10:9] charge_stage
	logic [1:0] m_tuser;          // [1:0] status
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	lccl_pkg::cfg_idx_t cfg_index = lccl_pkg::CFG_CAPACITY;
	logic [15:0] cfg_data = '0;

	// register copies and charger state as the predictor sees them
	logic [15:0] shadow_capacity = '0;
	logic [13:0] shadow_rate = '0;
	logic [15:0] shadow_top_mv = '0;
	logic [7:0] shadow_duty_max = '0;
	lccl_pkg::stage_t pred_stage = lccl_pkg::STG_IDLE;
	logic [lccl_pkg::DUTY_BITS-1:0] pred_duty = '0;

	charge_res_t pending_results[$];
	plan_row_t dir_plan[$];
	int mismatches = 0;
	int stall_cycles = 0;
	int hold_left = 0;
	bit hold_start = 1'b0;
	bit quiet = 1'b0;

	lipo_constant_current_charge_loop dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Advance the charger by one request and return the result it reports.
	function automatic charge_res_t charge_loop_step(lccl_pkg::req_t req, logic [15:0] volt,
			logic [15:0] amps);
		charge_res_t res;
		longint unsigned tgt, cur, mx, pm, step, nd, d, mask;
		mask = (64'd1 << lccl_pkg::DUTY_BITS) - 64'd1;
		tgt = (64'(shadow_capacity) * 64'(shadow_rate)) / 64'(lccl_pkg::PERMILLE);
		cur = amps[15] ? 64'd0 : 64'(amps);
		mx = (64'(shadow_duty_max) < mask) ? 64'(shadow_duty_max) : mask;
		d = 64'(pred_duty);
		res = NO_WANT;
		case (req)
			lccl_pkg::REQ_START: begin
				if (pred_stage != lccl_pkg::STG_IDLE) begin
					res.status = lccl_pkg::ST_BUSY;
				end else if (shadow_top_mv == 0 || shadow_top_mv > lccl_pkg::TOP_LIMIT_MV ||
						tgt == 0) begin
					res.status = lccl_pkg::ST_BAD_CFG;
				end else begin
					d = 0;
					res.wr = 1'b1;
					pred_stage = lccl_pkg::STG_CC;
				end
			end
			lccl_pkg::REQ_STOP: pred_stage = lccl_pkg::STG_IDLE;
			lccl_pkg::REQ_UPDATE: begin
				if (pred_stage == lccl_pkg::STG_IDLE) begin
					res.status = lccl_pkg::ST_IDLE_UPD;
				end else if (pred_stage == lccl_pkg::STG_CC) begin
					if (64'(volt) >= 64'(shadow_top_mv)) begin
						pred_stage = lccl_pkg::STG_CV;
					end else if (tgt > cur && tgt - cur > lccl_pkg::DEAD_BAND_MA) begin
						pm = ((tgt - cur) * lccl_pkg::PERMILLE / tgt) / 2;
						step = mx * pm / lccl_pkg::PERMILLE;
						if (d < mx) begin
							nd = d + step;
							d = (nd < mx) ? nd : mx;
							res.wr = 1'b1;
						end
					end else if (cur > tgt && cur - tgt > lccl_pkg::DEAD_BAND_MA) begin
						// a zero target counts as the largest error
						if (tgt == 0) begin
							step = mx;
						end else begin
							pm = ((cur - tgt) * lccl_pkg::PERMILLE / tgt) / 2;
							step = mx * pm / lccl_pkg::PERMILLE;
						end
						if (d > 0) begin
							d = (d > step) ? d - step : 64'd0;
							res.wr = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		pred_duty = d[lccl_pkg::DUTY_BITS-1:0];
		res.duty = 8'(pred_duty);
		res.stage = pred_stage;
		return res;
	endfunction

	task automatic send_item(lccl_pkg::req_t req, logic [15:0] volt, logic [15:0] amps,
			bit fixed, charge_res_t want);
		charge_res_t got;
		@(negedge clk);
		cfg_valid <= 1'b0;
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {amps, volt};
		do @(posedge clk); while (!s_tready);
		got = charge_loop_step(req, volt, amps);
		pending_results.push_back(fixed ? want : got);
	endtask

	task automatic write_reg(lccl_pkg::cfg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			lccl_pkg::CFG_CAPACITY: shadow_capacity = val;
			lccl_pkg::CFG_RATE: shadow_rate = val[13:0];
			lccl_pkg::CFG_TOP_V: shadow_top_mv = val;
			lccl_pkg::CFG_DUTY_MAX: shadow_duty_max = val[7:0];
		endcase
	endtask

	// Drop valid and wait until every expected result is back.
	task automatic settle_block();
		@(negedge clk);
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic maybe_gap();
		int n;
		if (!quiet && $urandom_range(0, 99) < 33) begin
			n = $urandom_range(1, 4);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// receiver: random stalls, or a long hold-off counted here
	always @(negedge clk) begin
		if (hold_start) begin
			hold_start = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(0, 99) >= 33);
		end
	end

	always @(posedge clk) begin
		charge_res_t seen, want;
		if (arst_n && m_tvalid && m_tready) begin
			seen.status = m_tuser;
			seen.duty = m_tdata[7:0];
			seen.wr = m_tdata[8];
			seen.stage = m_tdata[10:9];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d duty %0d write %0d stage %0d",
						seen.status, seen.duty, seen.wr, seen.stage);
			end else begin
				want = pending_results.pop_front();
				if (seen.status !== want.status || seen.duty !== want.duty ||
						seen.wr !== want.wr || seen.stage !== want.stage) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: status %0d/%0d duty %0d/%0d write %0d/%0d stage %0d/%0d",
							want.status, seen.status, want.duty, seen.duty,
							want.wr, seen.wr, want.stage, seen.stage);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int phase, len, k, r, tgt_i, spread, amp_i, items_done;
		lccl_pkg::req_t req;
		logic [15:0] volt, amps, c_cap, c_rate, c_top, c_dmax;

		dir_plan = '{
			'{ROW_ITEM, lccl_pkg::REQ_START, 16'd0, 16'd0, 1'b1,
				'{lccl_pkg::ST_BAD_CFG, 8'd0, 1'b0, lccl_pkg::STG_IDLE}},
			'{ROW_ITEM, lccl_pkg::REQ_UPDATE, 16'hFFFF, 16'h8000, 1'b1,
				'{lccl_pkg::ST_IDLE_UPD, 8'd0, 1'b0, lccl_pkg::STG_IDLE}},
			'{ROW_ITEM, lccl_pkg::REQ_STOP, 16'd0, 16'd0, 1'b1,
				'{lccl_pkg::ST_OK, 8'd0, 1'b0, lccl_pkg::STG_IDLE}},
			'{ROW_ITEM, REQ_RSVD, 16'hFFFF, 16'h7FFF, 1'b1,
				'{lccl_pkg::ST_OK, 8'd0, 1'b0, lccl_pkg::STG_IDLE}},
			'{ROW_CFG, lccl_pkg::CFG_TOP_V, 16'd4201, 16'd0, 1'b0, NO_WANT},
			'{ROW_CFG, lccl_pkg::CFG_CAPACITY, 16'd2000, 16'd0, 1'b0, NO_WANT},
			'{ROW_CFG, lccl_pkg::CFG_RATE, 16'd500, 16'd0, 1'b0, NO_WANT},
			'{ROW_CFG, lccl_pkg::CFG_DUTY_MAX, 16'd200, 16'd0, 1'b0, NO_WANT},
			'{ROW_ITEM, lccl_pkg::REQ_START, 16'd0, 16'd0, 1'b1,
				'{lccl_pkg::ST_BAD_CFG, 8'd0, 1'b0, lccl_pkg::STG_IDLE}},
			'{ROW_CFG, lccl_pkg::CFG_TOP_V, 16'd4200, 16'd0, 1'b0, NO_WANT},
			'{ROW_CFG, lccl_pkg::CFG_RATE, 16'd0, 16'd0, 1'b0, NO_WANT},
			'{ROW_ITEM, lccl_pkg::REQ_START, 16'd0, 16'd0, 1'b1,
				'{lccl_pkg::ST_BAD_CFG, 8'd0, 1'b0, lccl_pkg::STG_IDLE}},
			'{ROW_CFG, lccl_pkg::CFG_RATE, 16'd500, 16'd0, 1'b0, NO_WANT},
			'{ROW_ITEM, lccl_pkg::REQ_START, 16'd0, 16'd0, 1'b1,
				'{lccl_pkg::ST_OK, 8'd0, 1'b1, lccl_pkg::STG_CC}},
			'{ROW_ITEM, lccl_pkg::REQ_START, 16'd0, 16'd0, 1'b1,
				'{lccl_pkg::ST_BUSY, 8'd0, 1'b0, lccl_pkg::STG_CC}},
			'{ROW_ITEM, lccl_pkg::REQ_UPDATE, 16'd4199, 16'd0, 1'b0, NO_WANT},
			'{ROW_ITEM, lccl_pkg::REQ_UPDATE, 16'd0, 16'h8000, 1'b0, NO_WANT},
			'{ROW_ITEM, lccl_pkg::REQ_UPDATE, 16'd0, 16'd0, 1'b0, NO_WANT},
			'{ROW_ITEM, lccl_pkg::REQ_UPDATE, 16'd0, 16'd1030, 1'b0, NO_WANT},
			'{ROW_ITEM, lccl_pkg::REQ_UPDATE, 16'd0, 16'h7FFF, 1'b0, NO_WANT},
			'{ROW_ITEM, lccl_pkg::REQ_UPDATE, 16'd0, 16'h7FFF, 1'b0, NO_WANT},
			'{ROW_ITEM, lccl_pkg::REQ_UPDATE, 16'd4200, 16'd0, 1'b0, NO_WANT},
			'{ROW_ITEM, lccl_pkg::REQ_UPDATE, 16'd0, 16'd0, 1'b0, NO_WANT},
			'{ROW_ITEM, lccl_pkg::REQ_START, 16'd0, 16'd0, 1'b1,
				'{lccl_pkg::ST_BUSY, 8'd0, 1'b0, lccl_pkg::STG_CV}},
			'{ROW_ITEM, lccl_pkg::REQ_STOP, 16'd0, 16'd0, 1'b1,
				'{lccl_pkg::ST_OK, 8'd0, 1'b0, lccl_pkg::STG_IDLE}},
			'{ROW_CFG, lccl_pkg::CFG_DUTY_MAX, 16'd255, 16'd0, 1'b0, NO_WANT},
			'{ROW_CFG, lccl_pkg::CFG_TOP_V, 16'd1, 16'd0, 1'b0, NO_WANT},
			'{ROW_CFG, lccl_pkg::CFG_CAPACITY, 16'hFFFF, 16'd0, 1'b0, NO_WANT},
			'{ROW_CFG, lccl_pkg::CFG_RATE, 16'd10000, 16'd0, 1'b0, NO_WANT},
			'{ROW_ITEM, lccl_pkg::REQ_START, 16'd0, 16'd0, 1'b1,
				'{lccl_pkg::ST_OK, 8'd0, 1'b1, lccl_pkg::STG_CC}},
			'{ROW_ITEM, lccl_pkg::REQ_UPDATE, 16'd0, 16'd0, 1'b0, NO_WANT},
			'{ROW_ITEM, lccl_pkg::REQ_UPDATE, 16'd0, 16'd0, 1'b0, NO_WANT},
			'{ROW_ITEM, lccl_pkg::REQ_UPDATE, 16'd0, 16'd0, 1'b0, NO_WANT},
			// target drops to zero while charging: duty falls to zero
			'{ROW_CFG, lccl_pkg::CFG_RATE, 16'd0, 16'd0, 1'b0, NO_WANT},
			'{ROW_ITEM, lccl_pkg::REQ_UPDATE, 16'd0, 16'd31, 1'b0, NO_WANT},
			'{ROW_ITEM, lccl_pkg::REQ_UPDATE, 16'd1, 16'd0, 1'b0, NO_WANT}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_plan[i]) begin
			if (dir_plan[i].kind == ROW_CFG) begin
				settle_block();
				write_reg(lccl_pkg::cfg_idx_t'(dir_plan[i].code), dir_plan[i].arg0);
			end else begin
				send_item(lccl_pkg::req_t'(dir_plan[i].code), dir_plan[i].arg0,
					dir_plan[i].arg1, dir_plan[i].fixed, dir_plan[i].want);
				maybe_gap();
			end
		end

		items_done = 0;
		phase = 0;
		while (items_done < ITEM_GOAL) begin
			phase++;
			// sender pauses here until the block has answered everything
			settle_block();
			quiet = (phase == 2) || (phase == 4);

			r = $urandom_range(0, 9);
			c_cap = (phase == 1 || r == 0) ? 16'd0 :
				(r == 1) ? 16'hFFFF : 16'($urandom_range(50, 8000));
			r = $urandom_range(0, 9);
			c_rate = (r == 0) ? 16'd0 : (r == 1) ? 16'd10000 : 16'($urandom_range(1, 4000));
			r = $urandom_range(0, 24);
			if (phase == 1) c_top = 16'hFFFF;
			else if (r == 0) c_top = 16'd0;
			else if (r == 1) c_top = 16'($urandom_range(4201, 65535));
			else if (r == 2) c_top = 16'd4200;
			else if (r == 3) c_top = 16'd1;
			else c_top = 16'($urandom_range(2500, 4199));
			r = $urandom_range(0, 9);
			c_dmax = (phase == 1 || r == 0) ? 16'd0 :
				(r == 1) ? 16'd255 : 16'($urandom_range(1, 254));
			write_reg(lccl_pkg::CFG_CAPACITY, c_cap);
			write_reg(lccl_pkg::CFG_RATE, c_rate);
			write_reg(lccl_pkg::CFG_TOP_V, c_top);
			write_reg(lccl_pkg::CFG_DUTY_MAX, c_dmax);

			// hold the receiver off while items keep coming, so the input stalls
			if (phase == 4) hold_start = 1'b1;

			tgt_i = int'((64'(shadow_capacity) * 64'(shadow_rate)) /
				64'(lccl_pkg::PERMILLE));
			if (tgt_i > 32767) tgt_i = 32767;
			spread = tgt_i / 2 + 60;
			len = $urandom_range(30, 90);
			for (k = 0; k < len; k++) begin
				r = $urandom_range(0, 99);
				if (pred_stage == lccl_pkg::STG_IDLE && r < 60) req = lccl_pkg::REQ_START;
				else if (r < 64) req = lccl_pkg::REQ_START;
				else if (r < 69) req = lccl_pkg::REQ_STOP;
				else if (r < 72) req = REQ_RSVD;
				else req = lccl_pkg::REQ_UPDATE;

				r = $urandom_range(0, 99);
				if (r < 3) volt = shadow_top_mv;
				else if (r < 85 && shadow_top_mv != 0)
					volt = 16'($urandom_range(0, shadow_top_mv - 1));
				else volt = 16'($urandom_range(0, 65535));

				if ($urandom_range(0, 3) == 0) begin
					amps = 16'($urandom);
				end else begin
					amp_i = tgt_i - spread + int'($urandom_range(0, 2 * spread));
					if (amp_i > 32767) amp_i = 32767;
					if (amp_i < -32768) amp_i = -32768;
					amps = 16'(amp_i);
				end

				send_item(req, volt, amps, 1'b0, NO_WANT);
				if (req != REQ_RSVD) items_done++;
				maybe_gap();
			end
		end

		settle_block();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
